/* hw/rtl/fdp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_pkg
// Shared types and constants of the FIFO demand paging manager.
// ----------------------------------------------------------------------------
package fdp_pkg;

	localparam int NUM_FRAMES = 16;
	localparam int NUM_PROCS  = 8;
	localparam int NUM_PAGES  = 64;

	localparam int FRAME_W = 4;
	localparam int PROC_W  = 3;
	localparam int PAGE_W  = 6;
	localparam int RANK_W  = 5;
	localparam int FCNT_W  = 5;
	localparam int PADDR_W = PROC_W + PAGE_W;
	localparam int PCNT_W  = 7;
	localparam int CFG_W   = 5;

	localparam logic [CFG_W-1:0] LOG2_MIN   = 5'd4;
	localparam logic [CFG_W-1:0] LOG2_MAX   = 5'd16;
	localparam logic [CFG_W-1:0] LOG2_RST   = 5'd12;
	localparam logic [CFG_W-1:0] FRAMES_RST = 5'd16;

	localparam logic REG_PAGE_LOG2 = 1'b0;
	localparam logic REG_FRAMES    = 1'b1;

	typedef enum logic [1:0] {
		OP_ACCESS = 2'd0,
		OP_ALLOC  = 2'd1,
		OP_FREE   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic               present;
		logic               dirty;
		logic               referenced;
		logic [FRAME_W-1:0] frame;
	} page_entry_t;

	typedef struct packed {
		logic              used;
		logic [PROC_W-1:0] proc;
		logic [PAGE_W-1:0] page;
		logic [RANK_W-1:0] rank;
	} frame_entry_t;

	typedef struct packed {
		logic [CFG_W-1:0]  lg;
		logic [FCNT_W-1:0] nfr;
	} cfg_t;

	typedef struct packed {
		logic               fault;
		logic [FRAME_W-1:0] frame;
		logic               evicted;
		logic [PROC_W-1:0]  vproc;
		logic [PAGE_W-1:0]  vpage;
		logic               writeback;
		logic               error;
	} result_t;

endpackage
`default_nettype wire

/* hw/rtl/fifo_demand_paging.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_demand_paging
// Per-process page tables over a shared frame pool, FIFO replacement.
// ----------------------------------------------------------------------------
//  channel   | signals                                         | handshake
//  ----------+-------------------------------------------------+----------------
//  command   | operation process_id address is_write           | start & !busy
//  result    | fault frame evicted victim_process victim_page  | done, 1 cycle
//            | writeback error                                 |
//  config    | cfg_index cfg_wdata                             | cfg_we
//
//  After reset a clearing pass writes all 512 page entries, one a cycle;
//  busy stays high for the whole pass (config writes are taken).
//  Hit: page table read and update. Fault with free frame: frame table scan.
//  Fault with eviction: scan, victim update, rank sweep.
//  Allocate/free: two frame sweeps, page clear.
//  The result word follows in the cycle after the last step; the receiver
//  cannot stall, so a result is never held.
// ----------------------------------------------------------------------------
module fifo_demand_paging (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 operation,
	input  wire logic [fdp_pkg::PROC_W-1:0] process_id,
	input  wire logic [31:0]                address,
	input  wire logic                       is_write,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic [fdp_pkg::CFG_W-1:0]  cfg_wdata,
	output logic                            done,
	output logic                            fault,
	output logic [fdp_pkg::FRAME_W-1:0]     frame,
	output logic                            evicted,
	output logic [fdp_pkg::PROC_W-1:0]      victim_process,
	output logic [fdp_pkg::PAGE_W-1:0]      victim_page,
	output logic                            writeback,
	output logic                            error
);

	logic [fdp_pkg::CFG_W-1:0] page_size_log2_q;
	logic [fdp_pkg::CFG_W-1:0] frames_in_use_q;
	fdp_pkg::cfg_t             cfg;
	fdp_pkg::result_t          res;

	// config registers, raw values kept as written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_log2_q <= fdp_pkg::LOG2_RST;
			frames_in_use_q  <= fdp_pkg::FRAMES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fdp_pkg::REG_PAGE_LOG2: page_size_log2_q <= cfg_wdata;
				fdp_pkg::REG_FRAMES:    frames_in_use_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// clamp to the supported ranges
	always_comb begin
		if (page_size_log2_q < fdp_pkg::LOG2_MIN) begin
			cfg.lg = fdp_pkg::LOG2_MIN;
		end else if (page_size_log2_q > fdp_pkg::LOG2_MAX) begin
			cfg.lg = fdp_pkg::LOG2_MAX;
		end else begin
			cfg.lg = page_size_log2_q;
		end
		if (frames_in_use_q == '0) begin
			cfg.nfr = 5'd1;
		end else if (frames_in_use_q > fdp_pkg::FCNT_W'(fdp_pkg::NUM_FRAMES)) begin
			cfg.nfr = fdp_pkg::FCNT_W'(fdp_pkg::NUM_FRAMES);
		end else begin
			cfg.nfr = frames_in_use_q;
		end
	end

	fdp_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.start      (start),
		.operation  (operation),
		.process_id (process_id),
		.address    (address),
		.is_write   (is_write),
		.busy       (busy),
		.done       (done),
		.res        (res)
	);

	assign fault          = res.fault;
	assign frame          = res.frame;
	assign evicted        = res.evicted;
	assign victim_process = res.vproc;
	assign victim_page    = res.vpage;
	assign writeback      = res.writeback;
	assign error          = res.error;

endmodule
`default_nettype wire

/* hw/rtl/fdp_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fdp_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* hw/rtl/fdp_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fdp_seq
// Sequencer over the page table RAM and the frame table RAM.
// ----------------------------------------------------------------------------
module fdp_seq (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire fdp_pkg::cfg_t                cfg,
	input  wire logic                         start,
	input  wire logic [1:0]                   operation,
	input  wire logic [fdp_pkg::PROC_W-1:0]   process_id,
	input  wire logic [31:0]                  address,
	input  wire logic                         is_write,
	output logic                              busy,
	output logic                              done,
	output fdp_pkg::result_t                  res
);

	typedef enum logic [10:0] {
		ST_CLEAR  = 11'b00000000001,
		ST_IDLE   = 11'b00000000010,
		ST_PREAD  = 11'b00000000100,
		ST_SCAN   = 11'b00000001000,
		ST_VREAD  = 11'b00000010000,
		ST_FUPD   = 11'b00000100000,
		ST_EWRITE = 11'b00001000000,
		ST_RSCAN  = 11'b00010000000,
		ST_RUPD   = 11'b00100000000,
		ST_PCLR   = 11'b01000000000,
		ST_SPARE  = 11'b10000000000
	} state_t;

	localparam logic [fdp_pkg::FCNT_W-1:0] FLAST = fdp_pkg::FCNT_W'(fdp_pkg::NUM_FRAMES);
	localparam logic [fdp_pkg::PADDR_W-1:0] PLAST =
		fdp_pkg::PADDR_W'(fdp_pkg::NUM_PROCS * fdp_pkg::NUM_PAGES - 1);

	state_t                          state_q;
	logic [fdp_pkg::PADDR_W-1:0]     clr_q;
	logic [fdp_pkg::PROC_W-1:0]      pid_q;
	logic [fdp_pkg::PAGE_W-1:0]      page_q;
	logic                            wr_q;
	logic [fdp_pkg::PCNT_W-1:0]      cnt_q;
	logic                            aerr_q;
	logic [fdp_pkg::FCNT_W-1:0]      fa_q;
	logic                            free_q;
	logic                            any_q;
	logic [fdp_pkg::FRAME_W-1:0]     pick_q;
	logic [fdp_pkg::RANK_W-1:0]      best_q;
	logic [fdp_pkg::FRAME_W-1:0]     vic_q;
	logic [fdp_pkg::PROC_W-1:0]      vproc_q;
	logic [fdp_pkg::PAGE_W-1:0]      vpage_q;
	logic [fdp_pkg::RANK_W-1:0]      vrank_q;
	logic                            evict_q;
	logic                            wb_q;
	logic [fdp_pkg::NUM_FRAMES-1:0]  rel_q;
	logic [fdp_pkg::NUM_FRAMES-1:0]  relrank_q;
	logic                            pend_s1;
	logic [fdp_pkg::PADDR_W-1:0]     pend_addr_s1;
	logic [fdp_pkg::PCNT_W-1:0]      pcl_q;
	logic [fdp_pkg::RANK_W-1:0]      occ_q;
	logic                            done_q;
	fdp_pkg::result_t                res_q;

	// RAM ports
	logic                            pw_en, fw_en;
	logic [fdp_pkg::PADDR_W-1:0]     pw_addr, pr_addr;
	logic [fdp_pkg::FRAME_W-1:0]     fw_addr, fr_addr;
	fdp_pkg::page_entry_t            pw_data, prd;
	fdp_pkg::frame_entry_t           fw_data, frd;

	// request decode
	logic [31:0]                     page_full;
	logic                            page_oor;
	logic [32:0]                     need;
	logic                            need_big;

	// scan step
	logic [fdp_pkg::FRAME_W-1:0]     fi;
	logic                            flast;
	logic                            take_free, take_old;
	logic                            free_n, any_n;
	logic [fdp_pkg::FRAME_W-1:0]     pick_n, vic_n;
	logic [fdp_pkg::RANK_W-1:0]      best_n, vrank_n;
	logic [fdp_pkg::PROC_W-1:0]      vproc_n;
	logic [fdp_pkg::PAGE_W-1:0]      vpage_n;
	logic                            rmatch;
	logic [fdp_pkg::NUM_FRAMES-1:0]  below;
	logic [fdp_pkg::RANK_W-1:0]      rdec;

	fdp_ram #(.W($bits(fdp_pkg::page_entry_t)), .D(fdp_pkg::NUM_PROCS * fdp_pkg::NUM_PAGES))
	u_page_ram (
		.clk(clk), .we(pw_en), .waddr(pw_addr), .wdata(pw_data),
		.raddr(pr_addr), .rdata(prd)
	);

	fdp_ram #(.W($bits(fdp_pkg::frame_entry_t)), .D(fdp_pkg::NUM_FRAMES))
	u_frame_ram (
		.clk(clk), .we(fw_en), .waddr(fw_addr), .wdata(fw_data),
		.raddr(fr_addr), .rdata(frd)
	);

	always_comb begin
		page_full = address >> cfg.lg;
		page_oor  = page_full > 32'(fdp_pkg::NUM_PAGES - 1);
		need      = (33'(address) + ((33'd1 << cfg.lg) - 33'd1)) >> cfg.lg;
		need_big  = need > 33'(fdp_pkg::NUM_PAGES);
	end

	always_comb begin
		fi        = fdp_pkg::FRAME_W'(fa_q - 5'd1);
		flast     = fa_q == FLAST;
		take_free = !frd.used && ({1'b0, fi} < cfg.nfr) && !free_q;
		take_old  = frd.used && (frd.rank < best_q);
		free_n    = free_q | take_free;
		any_n     = any_q | frd.used;
		pick_n    = take_free ? fi : pick_q;
		best_n    = take_old ? frd.rank : best_q;
		vic_n     = take_old ? fi : vic_q;
		vproc_n   = take_old ? frd.proc : vproc_q;
		vpage_n   = take_old ? frd.page : vpage_q;
		vrank_n   = take_old ? frd.rank : vrank_q;
		rmatch    = frd.used && (frd.proc == pid_q);
		below     = (16'd1 << frd.rank[fdp_pkg::FRAME_W-1:0]) - 16'd1;
		rdec      = fdp_pkg::RANK_W'($countones(relrank_q & below));
	end

	always_comb begin
		pw_en   = 1'b0;
		pw_addr = {pid_q, page_q};
		pw_data = '0;
		pr_addr = {pid_q, page_q};
		fw_en   = 1'b0;
		fw_addr = fi;
		fw_data = '0;
		fr_addr = fa_q[fdp_pkg::FRAME_W-1:0];
		if (pend_s1) begin
			pw_en              = 1'b1;
			pw_addr            = pend_addr_s1;
			pw_data            = prd;
			pw_data.present    = 1'b0;
			pw_data.frame      = '0;
		end
		case (state_q)
			ST_CLEAR: begin
				pw_en   = 1'b1;
				pw_addr = clr_q;
				fw_en   = clr_q < fdp_pkg::PADDR_W'(fdp_pkg::NUM_FRAMES);
				fw_addr = clr_q[fdp_pkg::FRAME_W-1:0];
			end
			ST_IDLE: begin
				pr_addr = {process_id, page_full[fdp_pkg::PAGE_W-1:0]};
				fr_addr = '0;
			end
			ST_PREAD: begin
				fr_addr = '0;
				if (prd.present) begin
					pw_en              = 1'b1;
					pw_data            = prd;
					pw_data.dirty      = prd.dirty | wr_q;
					pw_data.referenced = 1'b1;
				end
			end
			ST_SCAN: begin
				if (flast) begin
					if (free_n || !any_n) begin
						fw_en   = 1'b1;
						fw_addr = free_n ? pick_n : '0;
						fw_data = '{used: 1'b1, proc: pid_q, page: page_q, rank: occ_q};
					end else begin
						pr_addr = {vproc_n, vpage_n};
					end
				end
			end
			ST_VREAD: begin
				pw_en              = 1'b1;
				pw_addr            = {vproc_q, vpage_q};
				pw_data.referenced = prd.referenced;
				fr_addr            = '0;
			end
			ST_FUPD: begin
				if (fi == pick_q) begin
					fw_en   = 1'b1;
					fw_data = '{used: 1'b1, proc: pid_q, page: page_q, rank: occ_q - 5'd1};
				end else if (frd.used && frd.rank > vrank_q) begin
					fw_en        = 1'b1;
					fw_data      = frd;
					fw_data.rank = frd.rank - 5'd1;
				end
			end
			ST_EWRITE: begin
				pw_en   = 1'b1;
				pw_data = '{present: 1'b1, dirty: wr_q, referenced: 1'b1, frame: pick_q};
			end
			ST_RSCAN: begin
				pr_addr = {pid_q, frd.page};
			end
			ST_RUPD: begin
				fw_en = 1'b1;
				if (!rel_q[fi] && frd.used) begin
					fw_data      = frd;
					fw_data.rank = frd.rank - rdec;
				end
			end
			ST_PCLR: begin
				pw_en   = 1'b1;
				pw_addr = {pid_q, pcl_q[fdp_pkg::PAGE_W-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			occ_q   <= '0;
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PLAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						pid_q     <= process_id;
						page_q    <= page_full[fdp_pkg::PAGE_W-1:0];
						wr_q      <= is_write;
						// free clears the whole table
						cnt_q     <= (need_big || operation != fdp_pkg::OP_ALLOC)
						             ? fdp_pkg::PCNT_W'(fdp_pkg::NUM_PAGES)
						             : need[fdp_pkg::PCNT_W-1:0];
						aerr_q    <= need_big && (operation == fdp_pkg::OP_ALLOC);
						fa_q      <= 5'd1;
						free_q    <= 1'b0;
						any_q     <= 1'b0;
						best_q    <= '1;
						evict_q   <= 1'b0;
						wb_q      <= 1'b0;
						rel_q     <= '0;
						relrank_q <= '0;
						res_q     <= '0;
						case (operation)
							fdp_pkg::OP_ACCESS: begin
								if (page_oor) begin
									done_q      <= 1'b1;
									res_q.error <= 1'b1;
								end else begin
									state_q <= ST_PREAD;
								end
							end
							fdp_pkg::OP_ALLOC, fdp_pkg::OP_FREE: begin
								state_q <= ST_RSCAN;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_PREAD: begin
					if (prd.present) begin
						done_q      <= 1'b1;
						res_q.frame <= prd.frame;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					fa_q    <= fa_q + 1'b1;
					free_q  <= free_n;
					any_q   <= any_n;
					pick_q  <= pick_n;
					best_q  <= best_n;
					vic_q   <= vic_n;
					vproc_q <= vproc_n;
					vpage_q <= vpage_n;
					vrank_q <= vrank_n;
					if (flast) begin
						if (free_n || !any_n) begin
							pick_q  <= free_n ? pick_n : '0;
							occ_q   <= occ_q + 1'b1;
							state_q <= ST_EWRITE;
						end else begin
							pick_q  <= vic_n;
							evict_q <= 1'b1;
							state_q <= ST_VREAD;
						end
					end
				end
				ST_VREAD: begin
					wb_q    <= prd.dirty;
					fa_q    <= 5'd1;
					state_q <= ST_FUPD;
				end
				ST_FUPD: begin
					fa_q <= fa_q + 1'b1;
					if (flast) begin
						state_q <= ST_EWRITE;
					end
				end
				ST_EWRITE: begin
					done_q          <= 1'b1;
					res_q.fault     <= 1'b1;
					res_q.frame     <= pick_q;
					res_q.evicted   <= evict_q;
					res_q.vproc     <= evict_q ? vproc_q : '0;
					res_q.vpage     <= evict_q ? vpage_q : '0;
					res_q.writeback <= wb_q;
					state_q         <= ST_IDLE;
				end
				ST_RSCAN: begin
					fa_q <= fa_q + 1'b1;
					if (rmatch) begin
						rel_q[fi]                                  <= 1'b1;
						relrank_q[frd.rank[fdp_pkg::FRAME_W-1:0]] <= 1'b1;
						pend_s1                                    <= 1'b1;
						pend_addr_s1                               <= {pid_q, frd.page};
					end
					if (flast) begin
						fa_q    <= 5'd1;
						state_q <= ST_RUPD;
					end
				end
				ST_RUPD: begin
					fa_q <= fa_q + 1'b1;
					if (flast) begin
						occ_q <= occ_q - fdp_pkg::RANK_W'($countones(rel_q));
						pcl_q <= '0;
						if (cnt_q == '0) begin
							done_q      <= 1'b1;
							res_q.error <= aerr_q;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_PCLR;
						end
					end
				end
				ST_PCLR: begin
					pcl_q <= pcl_q + 1'b1;
					if (pcl_q == cnt_q - 7'd1) begin
						done_q      <= 1'b1;
						res_q.error <= aerr_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;
	assign res  = res_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FLAST)
		else $error("occupied count above frame count");

	a_sweep_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_FUPD || state_q == ST_RSCAN ||
		 state_q == ST_RUPD) |-> (fa_q != 5'd0 && fa_q <= FLAST))
		else $error("frame sweep index out of range");

	a_pend_state: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_RSCAN || state_q == ST_RUPD))
		else $error("page release write outside release sweep");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result word while sequencer busy");

endmodule
`default_nettype wire
